[rtl/core/slab_pkg.sv]
// Shared types and constants for the serial line assembler.
package slab_pkg;

  localparam int LINE_MAX = 32;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int CNT_W    = IDX_W;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TAKE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EMIT = 2'd1,
    ST_TERM = 2'd2
  } back_st_t;

  // One queued command from the front to the back.
  typedef struct packed {
    op_t              op;
    logic             taken;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
    logic [CNT_W-1:0] cap;
  } q_entry_t;

endpackage

[rtl/core/serial_line_assembler_with_backspace_core.sv]
// Top level of the serial line assembler with backspace editing.
//
// Input channel (in_valid/in_ready): kind 0 carries a received byte in rx_byte,
// kind 1 asks for the ready line with a caller limit in take_limit.
// Output channel (out_valid/out_ready): line_char, line_taken and last.
// A received byte gives no word. A take gives one not-taken word, or the line
// bytes followed by a zero terminator with last set.
// The front updates the edit state and takes one word a cycle while the
// four-deep command queue has room. The back handles one store write or one
// output word at a time; a taken line with a nonzero cap enters the EMIT state
// before its first word is loaded; a not-taken answer loads straight from idle.
// Throughput is set by the single back unit: one store write or one output
// word per cycle, unless a stalled receiver holds the back.
// Reset clears the edit state, the queue and the output valid flag; the line
// store needs no clearing, as only bytes written for the current line are read.
// A stalled receiver holds the output register; the back then waits and the
// queue fills, after which in_ready drops.
module serial_line_assembler_with_backspace_core import slab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic [7:0] take_limit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_char,
  output logic       line_taken,
  output logic       last
);

  logic     push;
  q_entry_t push_entry;
  logic     q_ready;
  logic     q_valid;
  q_entry_t q_entry;
  logic     pop;

  slab_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .rx_byte    (rx_byte),
    .take_limit (take_limit),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  slab_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  slab_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_char  (line_char),
    .line_taken (line_taken),
    .last       (last)
  );

endmodule

[rtl/core/slab_front.sv]
// Front: accepts words, tracks the line being edited, issues store writes and take commands.
module slab_front import slab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic [7:0] take_limit,
  output logic       push,
  output q_entry_t   push_entry,
  input  logic       q_ready
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic             line_rdy;
  logic             line_rdy_next;
  logic [CNT_W-1:0] ready_length;
  logic [CNT_W-1:0] ready_length_next;
  logic             accept;
  logic [7:0]       limit_m1;
  logic [7:0]       rl_ext;
  logic [7:0]       cap_ext;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign limit_m1 = take_limit - 8'd1;
  assign rl_ext   = 8'(ready_length);
  assign cap_ext  = (limit_m1 < rl_ext) ? limit_m1 : rl_ext;

  always_comb begin
    fill_next         = fill;
    line_rdy_next     = line_rdy;
    ready_length_next = ready_length;
    push              = 1'b0;
    push_entry.op     = OP_WRITE;
    push_entry.taken  = 1'b0;
    push_entry.addr   = fill[IDX_W-1:0];
    push_entry.data   = rx_byte;
    push_entry.cap    = cap_ext[CNT_W-1:0];
    if (accept) begin
      if (kind == 1'b0) begin
        if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
          if (fill != '0) begin
            ready_length_next = fill;
            line_rdy_next     = 1'b1;
            fill_next         = '0;
          end
        end else if (rx_byte == CHAR_BS || rx_byte == CHAR_DEL) begin
          if (fill != '0) begin
            fill_next = fill - CNT_W'(1);
          end
        end else if (!line_rdy && fill < CNT_W'(LINE_MAX - 1)) begin
          push      = 1'b1;
          fill_next = fill + CNT_W'(1);
        end
      end else begin
        push          = 1'b1;
        push_entry.op = OP_TAKE;
        if (line_rdy && take_limit != 8'd0) begin
          push_entry.taken = 1'b1;
          line_rdy_next    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      line_rdy     <= 1'b0;
      ready_length <= '0;
    end else begin
      fill         <= fill_next;
      line_rdy     <= line_rdy_next;
      ready_length <= ready_length_next;
    end
  end

  // a pending line freezes editing, so nothing can be held beside it
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    line_rdy |-> fill == '0) else $error("bytes held while a line is pending");

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(LINE_MAX - 1)) else $error("fill count beyond store");

  a_take_nonzero: assert property (@(posedge clk) disable iff (rst)
    push && push_entry.op == OP_TAKE && push_entry.taken |-> ready_length != '0)
    else $error("empty line handed out");

endmodule

[rtl/core/slab_queue.sv]
// Short command queue between the front and the back.
module slab_queue import slab_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     q_ready,
  output logic     q_valid,
  output q_entry_t q_entry,
  input  logic     pop
);

  q_entry_t          ents [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_ready = count != QCNT_W'(QDEPTH);
  assign q_valid = count != '0;
  assign q_entry = ents[rd_ptr];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ents[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("queue count overrun");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("pop from empty queue");

endmodule

[rtl/core/slab_back.sv]
// Back: owns the line store, applies writes and plays taken lines out one word a cycle while the output is free.
module slab_back import slab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  q_entry_t   q_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_char,
  output logic       line_taken,
  output logic       last
);

  logic [7:0]       store [LINE_MAX];
  logic [7:0]       rdata;
  back_st_t         st;
  back_st_t         st_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_next;
  logic [CNT_W-1:0] n_inc;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] cap_next;
  logic             out_free;
  logic             wr_en;
  logic             load;
  logic [7:0]       ld_char;
  logic             ld_taken;
  logic             ld_last;

  assign out_free = !out_valid || out_ready;
  assign n_inc    = n + CNT_W'(1);

  always_comb begin
    st_next  = st;
    n_next   = n;
    cap_next = cap;
    pop      = 1'b0;
    wr_en    = 1'b0;
    load     = 1'b0;
    ld_char  = CHAR_NUL;
    ld_taken = 1'b0;
    ld_last  = 1'b0;
    case (st)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.op == OP_WRITE) begin
            pop   = 1'b1;
            wr_en = 1'b1;
          end else if (!q_entry.taken) begin
            if (out_free) begin
              pop     = 1'b1;
              load    = 1'b1;
              ld_last = 1'b1;
            end
          end else begin
            pop      = 1'b1;
            n_next   = '0;
            cap_next = q_entry.cap;
            st_next  = (q_entry.cap == '0) ? ST_TERM : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // rdata holds store[n] here; a zero byte ends the copy early
        if (rdata == CHAR_NUL) begin
          st_next = ST_TERM;
        end else if (out_free) begin
          load     = 1'b1;
          ld_char  = rdata;
          ld_taken = 1'b1;
          n_next   = n_inc;
          if (n_inc == cap) begin
            st_next = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (out_free) begin
          load     = 1'b1;
          ld_taken = 1'b1;
          ld_last  = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[q_entry.addr] <= q_entry.data;
    end
    rdata <= store[n_next];
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    cap <= cap_next;
    if (load) begin
      line_char  <= ld_char;
      line_taken <= ld_taken;
      last       <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_EMIT |-> n < cap) else $error("read beyond taken line");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> st == ST_IDLE) else $error("command popped mid-line");

  a_not_taken_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_taken |-> last && line_char == CHAR_NUL)
    else $error("malformed not-taken word");

endmodule

[bench/line_checker.sv]
// Checker for the line assembler: tracks the edit state, predicts words and compares them.
`timescale 1ns / 1ps

module line_checker import slab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic [7:0] take_limit,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] line_char,
  input  logic       line_taken,
  input  logic       last,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       taken;
    logic       fin;
  } line_word_t;

  line_word_t expected_words[$];

  logic [7:0] held_line [LINE_MAX];
  int         held_count;
  logic       line_done;
  int         done_length;
  int         error_count;

  assign errors  = error_count;
  assign pending = expected_words.size();

  // Apply one input word to the edit state and queue the words it gives.
  task automatic edit_or_take(input op_t op, input logic [7:0] b, input logic [7:0] lim);
    int cap;
    int n;
    if (op == OP_WRITE) begin
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (held_count != 0) begin
          done_length = held_count;
          line_done   = 1'b1;
          held_count  = 0;
        end
      end else if (b == CHAR_BS || b == CHAR_DEL) begin
        if (held_count != 0) held_count--;
      end else if (!line_done && held_count < LINE_MAX - 1) begin
        held_line[held_count] = b;
        held_count++;
      end
    end else if (!line_done || lim == 8'd0) begin
      expected_words.push_back('{ch: CHAR_NUL, taken: 1'b0, fin: 1'b1});
    end else begin
      line_done = 1'b0;
      cap = int'(lim) - 1;
      if (cap > done_length) cap = done_length;
      if (cap > LINE_MAX - 1) cap = LINE_MAX - 1;
      n = 0;
      // copy stops early at a stored NUL
      while (n < cap && held_line[n] != CHAR_NUL) begin
        expected_words.push_back('{ch: held_line[n], taken: 1'b1, fin: 1'b0});
        n++;
      end
      expected_words.push_back('{ch: CHAR_NUL, taken: 1'b1, fin: 1'b1});
    end
  endtask

  initial begin
    error_count = 0;
    held_count  = 0;
    line_done   = 1'b0;
    done_length = 0;
  end

  always @(posedge clk) begin
    line_word_t want;
    if (rst) begin
      held_count  = 0;
      line_done   = 1'b0;
      done_length = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word: char %02h taken %0b last %0b",
                   $time, line_char, line_taken, last);
        end else begin
          want = expected_words.pop_front();
          if (line_char !== want.ch || line_taken !== want.taken || last !== want.fin) begin
            error_count++;
            $display("%0t: mismatch: expected char %02h taken %0b last %0b, got char %02h taken %0b last %0b",
                     $time, want.ch, want.taken, want.fin, line_char, line_taken, last);
          end
        end
      end
      if (in_valid && in_ready) edit_or_take(op_t'(kind), rx_byte, take_limit);
    end
  end

endmodule

[bench/tb.sv]
// Testbench top: drives bytes and take requests into the line assembler and gives the verdict.
`timescale 1ns / 1ps

module tb import slab_pkg::*;;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       kind = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic [7:0] take_limit = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] line_char;
  logic       line_taken;
  logic       last;
  int         errors;
  int         pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  int sent_words = 0;

  serial_line_assembler_with_backspace_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .rx_byte(rx_byte), .take_limit(take_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_char(line_char), .line_taken(line_taken), .last(last)
  );

  line_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .rx_byte(rx_byte), .take_limit(take_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_char(line_char), .line_taken(line_taken), .last(last),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // Present one word at a falling edge and hold it until accepted.
  task automatic send_word(input op_t op, input logic [7:0] b, input logic [7:0] lim);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = op;
    rx_byte    = b;
    take_limit = lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(OP_WRITE, b, 8'($urandom_range(255)));
  endtask

  task automatic send_take(input logic [7:0] lim);
    send_word(OP_TAKE, 8'($urandom_range(255)), lim);
  endtask

  // A typed line with some edits, its end mark, at times extra bytes, then one or two takes.
  task automatic feed_line();
    int len;
    int r;
    logic [7:0] b;
    logic [7:0] lim;
    len = ($urandom_range(99) < 10) ? $urandom_range(40, 31) : $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 5)       b = CHAR_BS;
      else if (r < 10) b = CHAR_DEL;
      else if (r < 15) b = CHAR_NUL;
      else             b = 8'($urandom_range(255));
      send_byte(b);
    end
    send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 30)      lim = 8'($urandom_range(4));
    else if (r < 40) lim = 8'd0;
    else if (r < 50) lim = 8'hFF;
    else             lim = 8'($urandom_range(40, 1));
    send_take(lim);
    if ($urandom_range(99) < 10) send_take(8'($urandom_range(255)));
  endtask

  initial begin
    int target;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // take with nothing ready, line ends and edits on an empty line
    send_take(8'd5);
    send_byte(CHAR_LF);
    send_byte(CHAR_BS);
    send_byte(CHAR_DEL);
    send_byte("a");
    send_byte(8'hFF);
    send_byte(CHAR_BS);
    send_byte(8'h01);
    send_byte(CHAR_CR);
    send_byte("x");        // dropped, line pending
    send_take(8'd0);       // zero limit leaves the line ready
    send_take(8'd1);       // terminator only
    send_take(8'd9);
    // stored NUL cuts the copy short
    send_byte("q");
    send_byte(CHAR_NUL);
    send_byte("r");
    send_byte(CHAR_LF);
    send_take(8'hFF);
    send_byte("A");
    send_byte("B");
    send_byte("C");
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_take(8'd3);
    send_take(8'd2);

    target = sent_words;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      target += 86;
      while (sent_words < target) begin
        if ($urandom_range(99) < 15)
          send_word(op_t'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        else
          feed_line();
      end
      // hold off until the line words already owed have drained
      in_valid = 1'b0;
      wait (pending == 0);
      @(negedge clk);
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[serial_line_assembler_with_backspace_core.f]
rtl/core/slab_pkg.sv
rtl/core/slab_front.sv
rtl/core/slab_queue.sv
rtl/core/slab_back.sv
rtl/core/serial_line_assembler_with_backspace_core.sv
bench/line_checker.sv
bench/tb.sv
